@@ hdl/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
// Holds the command record passed from the parser to the output expander.
// No dependencies.
package jsu_pkg;

    // Out-of-band result kinds, also the command kinds in the queue
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam int unsigned LENGTH_BITS = 16;
    localparam int unsigned ERR_W       = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MAX_BYTES   = 4;
    localparam int unsigned IDX_W       = $clog2(MAX_BYTES);

    // Error codes carried with an error result
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_HEX    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_PAIR   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_ESCAPE = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_CLOSE   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_CONTROL    = 3'd5;
    localparam logic [ERR_W-1:0] ERR_NO_OPEN    = 3'd6;

    // m_tdata: out_byte, error_code, string_length, zero fill to whole bytes
    localparam int unsigned DATA_BITS   = BYTE_W + ERR_W + LENGTH_BITS;
    localparam int unsigned TDATA_W     = ((DATA_BITS + 7) / 8) * 8;

    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] byte_vec_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [IDX_W-1:0]       last_idx;  // number of bytes minus one
        byte_vec_t              bytes;
        logic [ERR_W-1:0]       err;
        logic [LENGTH_BITS-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] last_idx;
        byte_vec_t        bytes;
    } utf8_t;

    // UTF-8 encoding of one code point, up to four bytes
    function automatic utf8_t utf8_encode(input logic [20:0] u);
        utf8_t r;
        r.last_idx = '0;
        r.bytes    = '0;
        if (u <= 21'h00007F) begin
            r.bytes[0] = u[7:0];
        end else if (u <= 21'h0007FF) begin
            r.last_idx = IDX_W'(1);
            r.bytes[0] = {3'b110, u[10:6]};
            r.bytes[1] = {2'b10, u[5:0]};
        end else if (u <= 21'h00FFFF) begin
            r.last_idx = IDX_W'(2);
            r.bytes[0] = {4'b1110, u[15:12]};
            r.bytes[1] = {2'b10, u[11:6]};
            r.bytes[2] = {2'b10, u[5:0]};
        end else begin
            r.last_idx = IDX_W'(3);
            r.bytes[0] = {5'b11110, u[20:18]};
            r.bytes[1] = {2'b10, u[17:12]};
            r.bytes[2] = {2'b10, u[11:6]};
            r.bytes[3] = {2'b10, u[5:0]};
        end
        return r;
    endfunction

endpackage

@@ hdl/json_string_unescape_utf8_core.sv @@
// JSON string unescaper to UTF-8: top level.
// Input channel s_*: one byte of JSON text per transaction, starting at the
// opening quote; a zero byte marks end of text.
// Output channel m_*: decoded UTF-8 bytes (m_tuser 0), then one completion
// (m_tuser 1, carrying the saturated length) or one error (m_tuser 2, with
// its code). On an error, drop the bytes already passed for that string.
// m_tlast marks the final result caused by one input byte.
// The first result of a byte is written into the command queue and then
// loaded into the output register, where it drives m_tvalid.
// Throughput: one input byte per cycle while the output
// drains one result per cycle; a \u escape that expands to N UTF-8 bytes
// yields N results, one per byte, buffered by a four-entry command queue.
// When the receiver stalls, the queue fills and s_tready drops; nothing is
// lost. Reset (aresetn low, synchronous) empties the queue, clears the
// output valid flag and returns the parser to idle, awaiting an opening quote.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
module json_string_unescape_utf8_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] out_byte, [10:8] error_code, [26:11] string_length, rest zero
    output logic [jsu_pkg::TDATA_W-1:0]   m_tdata,
    output logic [1:0]                    m_tuser,   // [1:0] out_kind
    output logic                          m_tlast    // last_of_run
);

    jsu_pkg::cmd_t                     push_cmd;
    jsu_pkg::cmd_t                     head_cmd;
    logic                              push;
    logic                              pop;
    logic                              empty;
    logic                              full;
    logic [7:0]                        out_byte;
    logic [jsu_pkg::ERR_W-1:0]         out_err;
    logic [jsu_pkg::LENGTH_BITS-1:0]   out_len;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .cmd_full (full),
        .in_ready (s_tready),
        .cmd_push (push),
        .cmd      (push_cmd)
    );

    jsu_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .empty     (empty),
        .full      (full)
    );

    jsu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head_cmd),
        .empty   (empty),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_kind  (m_tuser),
        .m_byte  (out_byte),
        .m_err   (out_err),
        .m_len   (out_len),
        .m_last  (m_tlast)
    );

    assign m_tdata = jsu_pkg::TDATA_W'({out_len, out_err, out_byte});

endmodule

@@ hdl/jsu_front.sv @@
// Parser front end: accepts one text byte per cycle while the command queue is not full, and issues commands.
// Tracks escapes, \u groups and surrogate pairs; uses jsu_pkg.
module jsu_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              cmd_full,
    output logic              in_ready,
    output logic              cmd_push,
    output jsu_pkg::cmd_t     cmd
);

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_STR  = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_HEX1 = 3'd3;
    localparam logic [2:0] MODE_SBS  = 3'd4;
    localparam logic [2:0] MODE_SU   = 3'd5;
    localparam logic [2:0] MODE_HEX2 = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int unsigned LB = jsu_pkg::LENGTH_BITS;

    logic [2:0]    mode_reg,  mode_next;
    logic [15:0]   acc_reg,   acc_next;
    logic [9:0]    hs_reg,    hs_next;
    logic [1:0]    dcnt_reg,  dcnt_next;
    logic [LB-1:0] count_reg, count_next;

    logic          accept;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;

    // Hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    always_comb begin
        logic          do_fail;
        logic [2:0]    fail_code;
        logic          do_emit;
        logic          do_done;
        jsu_pkg::utf8_t enc;
        logic [4:0]    hd;
        logic [15:0]   acc_new;
        logic [20:0]   cp;
        logic [LB:0]   sum;

        mode_next  = mode_reg;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        dcnt_next  = dcnt_reg;
        count_next = count_reg;
        do_fail    = 1'b0;
        fail_code  = '0;
        do_emit    = 1'b0;
        do_done    = 1'b0;
        enc        = '0;
        hd         = hex_digit(in_byte);
        acc_new    = {acc_reg[11:0], hd[3:0]};
        cp         = {5'd0, acc_new} + 21'h010000
                     + {1'b0, hs_reg, 10'd0} - 21'h00DC00;
        sum        = '0;

        unique case (mode_reg)
            MODE_STR: begin
                if (in_byte == CH_QUOTE) begin
                    do_done = 1'b1;
                end else if (in_byte == CH_BSL) begin
                    mode_next = MODE_ESC;
                end else if (in_byte == 8'h00) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_NO_CLOSE;
                end else if (in_byte < CH_SPACE) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_CONTROL;
                end else begin
                    do_emit        = 1'b1;
                    enc.bytes[0]   = in_byte;
                end
            end
            MODE_ESC: begin
                mode_next = MODE_STR;
                do_emit   = 1'b1;
                case (in_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH: enc.bytes[0] = in_byte;
                    CH_B: enc.bytes[0] = 8'h08;
                    CH_F: enc.bytes[0] = 8'h0C;
                    CH_N: enc.bytes[0] = 8'h0A;
                    CH_R: enc.bytes[0] = 8'h0D;
                    CH_T: enc.bytes[0] = 8'h09;
                    CH_U: begin
                        do_emit   = 1'b0;
                        mode_next = MODE_HEX1;
                        acc_next  = '0;
                        dcnt_next = '0;
                    end
                    default: begin
                        do_emit   = 1'b0;
                        do_fail   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_ESCAPE;
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2: begin
                if (!hd[4]) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_HEX;
                end else if (dcnt_reg != 2'd3) begin
                    acc_next  = acc_new;
                    dcnt_next = dcnt_reg + 2'd1;
                end else begin
                    acc_next  = '0;
                    dcnt_next = '0;
                    if (mode_reg == MODE_HEX1) begin
                        if (acc_new[15:10] == 6'b110110) begin
                            hs_next   = acc_new[9:0];
                            mode_next = MODE_SBS;
                        end else begin
                            mode_next = MODE_STR;
                            do_emit   = 1'b1;
                            enc       = jsu_pkg::utf8_encode({5'd0, acc_new});
                        end
                    end else if (acc_new[15:10] != 6'b110111) begin
                        do_fail   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_PAIR;
                    end else begin
                        hs_next   = '0;
                        mode_next = MODE_STR;
                        do_emit   = 1'b1;
                        enc       = jsu_pkg::utf8_encode(cp);
                    end
                end
            end
            MODE_SBS: begin
                if (in_byte != CH_BSL) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_PAIR;
                end else begin
                    mode_next = MODE_SU;
                end
            end
            MODE_SU: begin
                if (in_byte != CH_U) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_PAIR;
                end else begin
                    mode_next = MODE_HEX2;
                    acc_next  = '0;
                    dcnt_next = '0;
                end
            end
            default: begin
                if (in_byte != CH_QUOTE) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_NO_OPEN;
                end else begin
                    mode_next  = MODE_STR;
                    acc_next   = '0;
                    hs_next    = '0;
                    dcnt_next  = '0;
                    count_next = '0;
                end
            end
        endcase

        // Saturating byte count
        if (do_emit) begin
            sum = {1'b0, count_reg} + (LB+1)'(enc.last_idx) + (LB+1)'(1);
            count_next = sum[LB] ? '1 : sum[LB-1:0];
        end

        if (do_fail || do_done) begin
            mode_next  = MODE_IDLE;
            acc_next   = '0;
            hs_next    = '0;
            dcnt_next  = '0;
            count_next = '0;
        end

        cmd          = '0;
        cmd.last_idx = enc.last_idx;
        cmd.bytes    = enc.bytes;
        if (do_done) begin
            cmd.kind     = jsu_pkg::KIND_DONE;
            cmd.last_idx = '0;
            cmd.len      = count_reg;  // length field is as wide as the counter
        end else if (do_fail) begin
            cmd.kind     = jsu_pkg::KIND_ERROR;
            cmd.last_idx = '0;
            cmd.bytes    = '0;
            cmd.err      = fail_code;
        end else begin
            cmd.kind     = jsu_pkg::KIND_BYTE;
        end
        cmd_push = accept && (do_emit || do_done || do_fail);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            hs_reg    <= '0;
            dcnt_reg  <= '0;
            count_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            hs_reg    <= hs_next;
            dcnt_reg  <= dcnt_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/jsu_fifo.sv @@
// Short command queue between the parser and the output expander.
// Flop storage, one push and one pop per cycle; uses jsu_pkg.
module jsu_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jsu_pkg::cmd_t push_data,
    input  logic          pop,
    output jsu_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    jsu_pkg::cmd_t                   mem_reg [jsu_pkg::FIFO_DEPTH];
    logic [jsu_pkg::FIFO_AW-1:0]     wr_reg, wr_next;
    logic [jsu_pkg::FIFO_AW-1:0]     rd_reg, rd_next;
    logic [jsu_pkg::FIFO_CW-1:0]     cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == jsu_pkg::FIFO_CW'(jsu_pkg::FIFO_DEPTH));
    assign head  = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + jsu_pkg::FIFO_AW'(1) : wr_reg;
        rd_next  = pop  ? rd_reg + jsu_pkg::FIFO_AW'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)      cnt_next = cnt_reg + jsu_pkg::FIFO_CW'(1);
        else if (pop && !push) cnt_next = cnt_reg - jsu_pkg::FIFO_CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

endmodule

@@ hdl/jsu_back.sv @@
// Output expander: turns each queued command into one to four results.
// Drives the registered result channel; uses jsu_pkg.
module jsu_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  jsu_pkg::cmd_t                      head,
    input  logic                               empty,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_kind,
    output logic [7:0]                         m_byte,
    output logic [jsu_pkg::ERR_W-1:0]          m_err,
    output logic [jsu_pkg::LENGTH_BITS-1:0]    m_len,
    output logic                               m_last
);

    logic                               valid_reg, valid_next;
    logic [jsu_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic [1:0]                         kind_reg;
    logic [7:0]                         byte_reg;
    logic [jsu_pkg::ERR_W-1:0]          err_reg;
    logic [jsu_pkg::LENGTH_BITS-1:0]    len_reg;
    logic                               last_reg;
    logic                               out_free;
    logic                               load;
    logic                               at_last;

    assign out_free = !valid_reg || m_ready;
    assign load     = out_free && !empty;
    assign at_last  = (idx_reg == head.last_idx);
    assign pop      = load && at_last;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (out_free) valid_next = !empty;
        if (load)     idx_next   = at_last ? '0 : idx_reg + jsu_pkg::IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= head.kind;
            byte_reg <= head.bytes[idx_reg];
            err_reg  <= head.err;
            len_reg  <= head.len;
            last_reg <= at_last;
        end
    end

    assign m_valid = valid_reg;
    assign m_kind  = kind_reg;
    assign m_byte  = byte_reg;
    assign m_err   = err_reg;
    assign m_len   = len_reg;
    assign m_last  = last_reg;

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && kind_reg != jsu_pkg::KIND_BYTE |-> last_reg)
        else $error("completion or error result without tlast");

    a_partial_keeps_head: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != '0 |-> !empty)
        else $error("command left the queue before all bytes were sent");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> idx_reg <= head.last_idx)
        else $error("byte index beyond command length");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !valid_reg)
        else $error("result valid straight after reset");

endmodule
